>>> rtl/utc_ldt_pkg.sv
// ----------------------------------------------------------------------------
// UTC to local day/time package
// Payload types, calendar constants and small lookup functions shared by the
// UTC date to local day number converter.
// ----------------------------------------------------------------------------
package utc_ldt_pkg;

  localparam int unsigned FirstYear   = 2000;
  localparam int unsigned LastYear    = 2099;
  localparam int unsigned SpanDays    = 36525;
  localparam int unsigned MinPerDay   = 24 * 60;
  localparam int signed   OffsetMin   = -48;
  localparam int signed   OffsetMax   = 56;
  // Reciprocal constants: x / 7 = (x * 37450) >> 18 for x below 43693,
  // and t / 60 = (t * 1093) >> 16 for t below 1440.
  localparam int unsigned Recip7      = 37450;
  localparam int unsigned Recip7Shift = 18;
  localparam int unsigned Recip60     = 1093;
  localparam int unsigned Recip60Shift = 16;
  localparam int unsigned WeekdayBase = 5;

  typedef struct packed {
    logic [13:0] utc_year;
    logic [3:0]  utc_month;
    logic [4:0]  utc_day;
    logic [4:0]  utc_hour;
    logic [5:0]  utc_minute;
    logic [5:0]  utc_second;
  } utc_in_t;

  typedef struct packed {
    logic        result_valid;
    logic [15:0] local_day_number;
    logic [2:0]  local_weekday;
    logic [4:0]  local_hour;
    logic [5:0]  local_minute;
    logic [5:0]  local_second;
  } utc_out_t;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StYear  = 6'b000010,
    StDate  = 6'b000100,
    StShift = 6'b001000,
    StMul   = 6'b010000,
    StDone  = 6'b100000
  } utc_state_e;

  // Days in a month; February gets 29 in a leap year, invalid months get 0.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of the month in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] days;
    unique case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

>>> rtl/utc_date_to_local_day_time.sv
// ----------------------------------------------------------------------------
// UTC date to local day number and time of day
// Converts a UTC calendar date and time to the local day number since
// 2000-01-01, weekday and local time, using a quarter-hour zone offset.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+---------------------------
//  in      | input     | in_valid_i/in_stall_o   | in_data_i  (utc_in_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (utc_out_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (zone offset)
//
//  After its input transfer, a result passes the year loop (365 or 366 days added per
//  year, none for an invalid input or offset), then the date, shift, multiply and done
//  steps. The next input is taken in the cycle after the result is loaded.
//  The input is stalled from acceptance until the result is loaded into the
//  output register; a new transfer may be taken while that result still waits.
//  A stalled output holds the sequencer in its last step.
//  Reset clears the zone offset to 0 and empties the output register.
module utc_date_to_local_day_time
  import utc_ldt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  utc_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output utc_out_t        out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic signed [6:0] cfg_data_i
);

  utc_state_e        state_q, state_d;
  utc_in_t           in_q;
  logic signed [6:0] off_q;
  logic [6:0]        cnt_q;
  logic [15:0]       acc_q;
  logic signed [12:0] total_q;
  logic              ok_q;
  logic [31:0]       mul_day_q;
  logic [21:0]       mul_min_q;
  utc_out_t          out_q;
  logic              out_valid_q;

  logic              in_accept;
  logic              out_free;
  logic [13:0]       year_off;
  logic [6:0]        yrs;
  logic              leap;
  logic              in_ok;
  logic [15:0]       dnum_date;
  logic signed [12:0] off15;
  logic signed [12:0] total_date;
  logic [15:0]       day_plus;
  logic [13:0]       quot7;
  logic [16:0]       times7;
  logic [16:0]       rem7;
  logic [4:0]        hour_loc;
  logic [12:0]       min_loc;
  utc_out_t          res;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Within 2000 to 2099 the leap rule reduces to a multiple of four.
  assign year_off = in_q.utc_year - 14'(FirstYear);
  assign yrs      = year_off[6:0];
  assign leap     = (yrs[1:0] == 2'b00);

  always_comb begin
    in_ok = 1'b1;
    if (in_q.utc_year < 14'(FirstYear) || in_q.utc_year > 14'(LastYear)) in_ok = 1'b0;
    if (in_q.utc_day == 5'd0 || in_q.utc_day > month_len(in_q.utc_month, leap)) in_ok = 1'b0;
    if (in_q.utc_hour >= 5'd24 || in_q.utc_minute >= 6'd60 || in_q.utc_second >= 6'd60) begin
      in_ok = 1'b0;
    end
    if (off_q < 7'(OffsetMin) || off_q > 7'(OffsetMax)) in_ok = 1'b0;
  end

  assign dnum_date = acc_q + 16'(month_start(in_q.utc_month)) + 16'(in_q.utc_day) - 16'd1
                   + 16'((in_q.utc_month > 4'd2) && leap);
  assign off15      = (13'(off_q) <<< 4) - 13'(off_q);
  assign total_date = (13'(in_q.utc_hour) <<< 6) - (13'(in_q.utc_hour) <<< 2)
                    + 13'(in_q.utc_minute) + off15;

  assign day_plus = acc_q + 16'(WeekdayBase);
  assign quot7    = mul_day_q[31:Recip7Shift];
  assign times7   = (17'(quot7) << 3) - 17'(quot7);
  assign rem7     = 17'(day_plus) - times7;
  assign hour_loc = mul_min_q[Recip60Shift +: 5];
  assign min_loc  = 13'(total_q) - ((13'(hour_loc) << 6) - (13'(hour_loc) << 2));

  always_comb begin
    res = '0;
    if (ok_q) begin
      res.result_valid     = 1'b1;
      res.local_day_number = acc_q;
      res.local_weekday    = rem7[2:0];
      res.local_hour       = hour_loc;
      res.local_minute     = min_loc[5:0];
      res.local_second     = in_q.utc_second;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_accept) state_d = StYear;
      StYear:  if (!in_ok || cnt_q == yrs) state_d = StDate;
      StDate:  state_d = StShift;
      StShift: state_d = StMul;
      StMul:   state_d = StDone;
      StDone:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) off_q <= cfg_data_i;
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath; the accumulator acc_q is shared by the year loop, the date step and the day shift.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          in_q  <= in_data_i;
          cnt_q <= '0;
          acc_q <= '0;
        end
      end
      StYear: begin
        if (in_ok && cnt_q != yrs) begin
          acc_q <= acc_q + ((cnt_q[1:0] == 2'b00) ? 16'd366 : 16'd365);
          cnt_q <= cnt_q + 7'd1;
        end
      end
      StDate: begin
        ok_q    <= in_ok;
        acc_q   <= dnum_date;
        total_q <= total_date;
      end
      StShift: begin
        if (total_q < 0) begin
          if (acc_q == '0) begin
            ok_q <= 1'b0;
          end else begin
            acc_q   <= acc_q - 16'd1;
            total_q <= total_q + 13'(MinPerDay);
          end
        end else if (total_q >= 13'(MinPerDay)) begin
          acc_q   <= acc_q + 16'd1;
          total_q <= total_q - 13'(MinPerDay);
        end
      end
      StMul: begin
        ok_q      <= ok_q && (acc_q < 16'(SpanDays));
        mul_day_q <= 32'(day_plus) * 32'(Recip7);
        mul_min_q <= 22'(total_q[10:0]) * 22'(Recip60);
      end
      StDone: begin
        if (out_free) out_q <= res;
      end
      default: ;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == StYear)
    else $error("accepted transfer did not start the year loop");

  a_year_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StYear |-> cnt_q <= 7'd100)
    else $error("year counter ran past the supported span");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.result_valid |->
      out_data_o.local_day_number == '0 && out_data_o.local_weekday == '0 &&
      out_data_o.local_hour == '0 && out_data_o.local_minute == '0 &&
      out_data_o.local_second == '0)
    else $error("invalid result carries nonzero fields");

  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_valid |->
      out_data_o.local_day_number < 16'(SpanDays) && out_data_o.local_weekday < 3'd7 &&
      out_data_o.local_hour < 5'd24 && out_data_o.local_minute < 6'd60)
    else $error("valid result field out of range");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone && !out_free |=> state_q == StDone && out_valid_q)
    else $error("result dropped while output was stalled");

endmodule

>>> sim/utc_ldt_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTC to local day/time scoreboard
// Calendar helpers and a scoreboard that converts every accepted UTC date to
// the local day number and time it expects, then checks the block's results
// in order.
// ----------------------------------------------------------------------------
package utc_ldt_tb_pkg;
  import utc_ldt_pkg::*;

  localparam int unsigned MonthDays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned DaysBefore[12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  function automatic bit leap_year(int unsigned year);
    return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
  endfunction

  // Length of the month, 0 for a month number that does not exist.
  function automatic int unsigned days_in_month(int unsigned year, int unsigned month);
    if (month < 1 || month > 12) return 0;
    if (month == 2 && leap_year(year)) return 29;
    return MonthDays[month-1];
  endfunction

  class local_time_scoreboard;
    utc_out_t          local_time_q[$];
    logic signed [6:0] zone_offset;
    int unsigned       errors;

    function new();
      zone_offset = '0;
      errors      = 0;
    endfunction

    function void set_offset(logic signed [6:0] quarters);
      zone_offset = quarters;
    endfunction

    function utc_out_t convert_to_local(utc_in_t date);
      int unsigned yr, mo, dy, hr, mn, sc, len, yoff, dnum;
      int          off, minutes;
      bit          ok;
      utc_out_t    r;
      yr  = date.utc_year;
      mo  = date.utc_month;
      dy  = date.utc_day;
      hr  = date.utc_hour;
      mn  = date.utc_minute;
      sc  = date.utc_second;
      off = zone_offset;
      len = days_in_month(yr, mo);
      ok  = (yr >= FirstYear) && (yr <= LastYear) && (dy >= 1) && (dy <= len) &&
            (hr < 24) && (mn < 60) && (sc < 60) && (off >= OffsetMin) && (off <= OffsetMax);
      r = '0;
      dnum = 0;
      minutes = 0;
      if (ok) begin
        yoff = yr - FirstYear;
        dnum = 365 * yoff + (yoff + 3) / 4 + DaysBefore[mo-1] + dy - 1;
        if (mo > 2 && leap_year(yr)) dnum++;
        minutes = int'(hr * 60 + mn) + off * 15;
        // The offset moves the time by at most one day either way.
        if (minutes < 0) begin
          if (dnum == 0) begin
            ok = 1'b0;
          end else begin
            dnum--;
            minutes += int'(MinPerDay);
          end
        end else if (minutes >= int'(MinPerDay)) begin
          dnum++;
          minutes -= int'(MinPerDay);
        end
        if (dnum >= SpanDays) ok = 1'b0;
      end
      // An invalid result carries zeros in every field.
      if (ok) begin
        r.result_valid     = 1'b1;
        r.local_day_number = 16'(dnum);
        r.local_weekday    = 3'((WeekdayBase + dnum) % 7);
        r.local_hour       = 5'(minutes / 60);
        r.local_minute     = 6'(minutes % 60);
        r.local_second     = 6'(sc);
      end
      return r;
    endfunction

    function void note_input(utc_in_t date);
      local_time_q.push_back(convert_to_local(date));
    endfunction

    function int unsigned pending();
      return local_time_q.size();
    endfunction

    function void check_result(utc_out_t got);
      utc_out_t exp;
      if (local_time_q.size() == 0) begin
        $error("result transfer with no conversion pending: %p", got);
        errors++;
        return;
      end
      exp = local_time_q.pop_front();
      if (got.result_valid !== exp.result_valid) begin
        $error("result_valid: expected %0d, actual %0d", exp.result_valid, got.result_valid);
        errors++;
      end
      if (got.local_day_number !== exp.local_day_number) begin
        $error("local_day_number: expected %0d, actual %0d",
               exp.local_day_number, got.local_day_number);
        errors++;
      end
      if (got.local_weekday !== exp.local_weekday) begin
        $error("local_weekday: expected %0d, actual %0d", exp.local_weekday, got.local_weekday);
        errors++;
      end
      if (got.local_hour !== exp.local_hour) begin
        $error("local_hour: expected %0d, actual %0d", exp.local_hour, got.local_hour);
        errors++;
      end
      if (got.local_minute !== exp.local_minute) begin
        $error("local_minute: expected %0d, actual %0d", exp.local_minute, got.local_minute);
        errors++;
      end
      if (got.local_second !== exp.local_second) begin
        $error("local_second: expected %0d, actual %0d", exp.local_second, got.local_second);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> sim/tb_utc_date_to_local_day_time.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTC date to local day/time testbench
// Drives directed calendar edge cases and random dates through the converter
// under a series of zone offsets, with random idle cycles on both channels,
// and checks every result against the scoreboard's own conversion.
// ----------------------------------------------------------------------------
module tb_utc_date_to_local_day_time;
  import utc_ldt_pkg::*;
  import utc_ldt_tb_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 120;
  localparam int unsigned NumPhases    = 10;
  localparam int PhaseOffset[NumPhases] = '{56, -48, -64, 63, -49, 57, 1, -20, 0, 0};
  localparam int unsigned CalmPhase    = 6;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  utc_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  utc_out_t          out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic signed [6:0] cfg_data;
  logic              calm;
  int unsigned       cycle_count = 0;

  local_time_scoreboard sb = new();

  utc_date_to_local_day_time dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL utc_date_to_local_day_time");
      $finish;
    end
  end

  // Signals are stable at the falling edge, so a transfer seen here happens at
  // the next rising edge.
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= !calm && ($urandom_range(0, 99) < 30);
    end
  end

  function automatic utc_in_t make_date(int unsigned y, int unsigned mo, int unsigned d,
                                        int unsigned h, int unsigned mi, int unsigned s);
    utc_in_t t;
    t.utc_year   = 14'(y);
    t.utc_month  = 4'(mo);
    t.utc_day    = 5'(d);
    t.utc_hour   = 5'(h);
    t.utc_minute = 6'(mi);
    t.utc_second = 6'(s);
    return t;
  endfunction

  // Mostly well-formed dates, biased toward the ends of the span and toward
  // times near midnight; the rest are raw noise or have one field broken.
  function automatic utc_in_t random_date();
    int unsigned kind, y, mo, d, h, len;
    utc_in_t     t;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      return make_date($urandom_range(0, 9999), $urandom_range(0, 15), $urandom_range(0, 31),
                       $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
    end
    if ($urandom_range(0, 3) == 0) y = ($urandom_range(0, 1) == 0) ? 2000 : 2099;
    else y = 2000 + $urandom_range(0, 99);
    mo = $urandom_range(1, 12);
    d  = $urandom_range(1, days_in_month(y, mo));
    if (y == 2000 && $urandom_range(0, 1) == 0) begin
      mo = 1;
      d  = 1;
    end
    if (y == 2099 && $urandom_range(0, 1) == 0) begin
      mo = 12;
      d  = 31;
    end
    if ($urandom_range(0, 2) == 0) begin
      h = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(20, 23);
    end else begin
      h = $urandom_range(0, 23);
    end
    t = make_date(y, mo, d, h, $urandom_range(0, 59), $urandom_range(0, 59));
    if (kind < 18) begin
      len = days_in_month(y, mo);
      case ($urandom_range(0, 4))
        0: t.utc_day = 5'd0;
        1: t.utc_day = (len == 31) ? 5'd0 : 5'(len + 1);
        2: t.utc_hour = 5'($urandom_range(24, 31));
        3: t.utc_minute = 6'($urandom_range(60, 63));
        default: t.utc_second = 6'($urandom_range(60, 63));
      endcase
    end
    return t;
  endfunction

  task automatic wait_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic pace_input();
    int unsigned roll, gap;
    roll = $urandom_range(0, 99);
    if (calm) return;
    if (roll < 2) begin
      wait_results();
    end else if (roll < 30) begin
      // Mostly short gaps, now and then one longer than a whole conversion.
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 130) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_date(input utc_in_t date);
    bit taken;
    in_valid <= 1'b1;
    in_data  <= date;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_input(date);
    pace_input();
  endtask

  // The offset register is only written once every conversion has drained.
  task automatic write_offset(input logic signed [6:0] quarters);
    bit taken;
    wait_results();
    cfg_valid <= 1'b1;
    cfg_data  <= quarters;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    sb.set_offset(quarters);
  endtask

  initial begin
    int quarters;
    int unsigned count;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    calm      <= 1'b0;
    rst_n     <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Calendar edges at the reset offset of zero.
    send_date(make_date(2000, 1, 1, 0, 0, 0));
    send_date(make_date(2099, 12, 31, 23, 59, 59));
    send_date(make_date(2000, 2, 29, 12, 30, 30));
    send_date(make_date(2001, 2, 29, 12, 0, 0));
    send_date(make_date(2000, 3, 1, 0, 0, 0));
    send_date(make_date(2096, 2, 29, 6, 15, 45));
    send_date(make_date(1999, 12, 31, 23, 59, 59));
    send_date(make_date(2100, 1, 1, 0, 0, 0));
    send_date(make_date(0, 0, 0, 0, 0, 0));
    send_date(make_date(9999, 15, 31, 31, 63, 63));
    send_date(make_date(8191, 12, 31, 23, 59, 59));
    send_date(make_date(2050, 4, 31, 10, 0, 0));
    send_date(make_date(2050, 13, 1, 10, 0, 0));
    send_date(make_date(2050, 6, 15, 24, 0, 0));
    send_date(make_date(2050, 6, 15, 23, 60, 0));
    send_date(make_date(2050, 6, 15, 23, 59, 60));
    send_date(make_date(2050, 1, 0, 8, 0, 0));
    send_date(make_date(2023, 11, 31, 8, 0, 0));

    for (int unsigned p = 0; p < NumPhases; p++) begin
      quarters = (p == NumPhases - 1) ? int'($urandom_range(0, 104)) - 48 : PhaseOffset[p];
      write_offset(7'(quarters));
      calm <= (p == CalmPhase);
      // Dates at the two ends of the span, right on its local ends at the extreme offsets.
      send_date(make_date(2000, 1, 1, 11, 59, $urandom_range(0, 59)));
      send_date(make_date(2000, 1, 1, 12, 0, $urandom_range(0, 59)));
      send_date(make_date(2099, 12, 31, 9, 59, $urandom_range(0, 59)));
      send_date(make_date(2099, 12, 31, 10, 0, $urandom_range(0, 59)));
      count = (quarters < OffsetMin || quarters > OffsetMax) ? 15 : 65;
      repeat (count) send_date(random_date());
    end

    wait_results();
    repeat (SettleCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS utc_date_to_local_day_time");
    end else begin
      $display("FAIL utc_date_to_local_day_time");
    end
    $finish;
  end

endmodule
